// ===== hdl/stq_pkg.sv =====
// types, codes and constants shared by the sorted timeout queue
`timescale 1ns / 1ps

package stq_pkg;

    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [3:0]  MAX_RESULTS = 4'd15;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DEL  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_DELETED = 3'd2;
    localparam logic [2:0] KIND_BAD_ID  = 3'd3;
    localparam logic [2:0] KIND_EXPIRED = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now;
        logic [31:0] deadline;
        logic [31:0] user_tag;
        logic [3:0]  target_slot;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] tag_out;
        logic        last;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_A_RDO,
        ST_A_RDD,
        ST_A_CMP,
        ST_A_SRD,
        ST_A_SWR,
        ST_A_PUT,
        ST_D_RD,
        ST_D_CHK,
        ST_D_DONE,
        ST_T_HEAD,
        ST_T_HD,
        ST_T_DL,
        ST_T_EVAL,
        ST_T_SRD,
        ST_T_SWR,
        ST_T_FIN,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/stq_ram.sv =====
// simple dual-port synchronous ram, one write port and one registered read port
`timescale 1ns / 1ps

module stq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/stq_ctrl.sv =====
// sequencer for add, delete and tick, with slot occupancy, count and output register
`timescale 1ns / 1ps

module stq_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  stq_pkg::in_t             in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output stq_pkg::out_t            out_data,
    output logic                     omem_we,
    output logic [$clog2(SLOTS)-1:0] omem_waddr,
    output logic [$clog2(SLOTS)-1:0] omem_wdata,
    output logic [$clog2(SLOTS)-1:0] omem_raddr,
    input  logic [$clog2(SLOTS)-1:0] omem_rdata,
    output logic                     dmem_we,
    output logic [$clog2(SLOTS)-1:0] dmem_waddr,
    output logic [63:0]              dmem_wdata,
    output logic [$clog2(SLOTS)-1:0] dmem_raddr,
    input  logic [63:0]              dmem_rdata
);

    import stq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0]   LIVE_MAX  = IW'(SLOTS - 1);
    localparam logic [IW+3:0]   SLOTS_EXT = (IW + 4)'(SLOTS);

    state_t          state_reg, state_next;
    in_t             item_reg, item_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [IW-1:0]   live_reg, live_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   slot_reg, slot_next;
    logic            found_reg, found_next;
    logic [31:0]     nd_reg, nd_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [IW-1:0]   pend_slot_reg, pend_slot_next;
    logic [31:0]     pend_tag_reg, pend_tag_next;
    logic [31:0]     hdl_reg, hdl_next;
    logic [31:0]     htag_reg, htag_next;
    out_t            res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    out_t            out_data_reg, out_data_next;

    logic            can_load;
    logic [IW-1:0]   free_slot;
    logic            free_found;
    logic            table_full;
    logic [IW+3:0]   tgt_ext;
    logic [IW-1:0]   tgt_idx;
    logic            bad_del;
    logic [31:0]     cmp_dist;
    logic            closer;
    logic [31:0]     age;
    logic            expired;
    logic [IW:0]     idx_inc;
    logic [IW:0]     idx_inc2;
    logic [IW:0]     live_ext;

    function automatic logic [3:0] to_slot4(input logic [IW-1:0] s);
        logic [IW+3:0] ext;
        ext = {4'b0, s};
        return ext[3:0];
    endfunction

    assign can_load  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int s = SLOTS - 1; s >= 1; s--)
        begin
            if (!busy_reg[s])
            begin
                free_slot  = IW'(s);
                free_found = 1'b1;
            end
        end
    end

    assign table_full = (live_reg >= LIVE_MAX) || !free_found;
    assign tgt_ext    = {{IW{1'b0}}, item_reg.target_slot};
    assign tgt_idx    = tgt_ext[IW-1:0];
    assign bad_del    = (item_reg.target_slot == 4'd0) || (tgt_ext >= SLOTS_EXT)
                        || !busy_reg[tgt_idx];
    assign cmp_dist   = (dmem_rdata[63:32] - item_reg.now) ^ SIGN_BIT;
    assign closer     = nd_reg < cmp_dist;
    assign age        = item_reg.now - hdl_reg;
    assign expired    = !age[31];
    assign idx_inc    = {1'b0, idx_reg} + 1'b1;
    assign idx_inc2   = {1'b0, idx_reg} + 2'd2;
    assign live_ext   = {1'b0, live_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority case (item_reg.mode)
                    MODE_ADD:
                    begin
                        if (table_full)
                            state_next = ST_EMIT;
                        else if (live_reg == '0)
                            state_next = ST_A_PUT;
                        else
                            state_next = ST_A_RDO;
                    end
                    MODE_DEL:  state_next = bad_del ? ST_EMIT : ST_D_RD;
                    MODE_TICK: state_next = ST_T_HEAD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_A_RDO: state_next = ST_A_RDD;
            ST_A_RDD: state_next = ST_A_CMP;
            ST_A_CMP:
            begin
                if (closer || idx_inc == live_ext)
                    state_next = ST_A_SRD;
                else
                    state_next = ST_A_RDO;
            end
            ST_A_SRD: state_next = (idx_reg == pos_reg) ? ST_A_PUT : ST_A_SWR;
            ST_A_SWR: state_next = ST_A_SRD;
            ST_A_PUT: state_next = ST_EMIT;
            ST_D_RD:  state_next = ST_D_CHK;
            ST_D_CHK: state_next = (idx_inc == live_ext) ? ST_D_DONE : ST_D_RD;
            ST_D_DONE: state_next = ST_EMIT;
            ST_T_HEAD:
            begin
                if (live_reg == '0 || cnt_reg == MAX_RESULTS)
                    state_next = ST_T_FIN;
                else
                    state_next = ST_T_HD;
            end
            ST_T_HD: state_next = ST_T_DL;
            ST_T_DL: state_next = ST_T_EVAL;
            ST_T_EVAL:
            begin
                if (!expired)
                    state_next = ST_T_FIN;
                else if (pend_valid_reg && !can_load)
                    state_next = ST_T_EVAL;
                else if (live_reg == IW'(1))
                    state_next = ST_T_HEAD;
                else
                    state_next = ST_T_SRD;
            end
            ST_T_SRD: state_next = ST_T_SWR;
            ST_T_SWR: state_next = (idx_inc2 == live_ext) ? ST_T_HEAD : ST_T_SRD;
            ST_T_FIN:
            begin
                if (!(pend_valid_reg && !can_load))
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (can_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory and handshake outputs
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        omem_we    = 1'b0;
        omem_waddr = '0;
        omem_wdata = '0;
        omem_raddr = '0;
        dmem_we    = 1'b0;
        dmem_waddr = '0;
        dmem_wdata = '0;
        dmem_raddr = '0;
        unique case (state_reg)
            ST_A_RDO: omem_raddr = idx_reg;
            ST_A_RDD: dmem_raddr = omem_rdata;
            ST_A_SRD: omem_raddr = idx_reg - 1'b1;
            ST_A_SWR:
            begin
                omem_we    = 1'b1;
                omem_waddr = idx_reg;
                omem_wdata = omem_rdata;
            end
            ST_A_PUT:
            begin
                omem_we    = 1'b1;
                omem_waddr = pos_reg;
                omem_wdata = slot_reg;
                dmem_we    = 1'b1;
                dmem_waddr = slot_reg;
                dmem_wdata = {item_reg.deadline, item_reg.user_tag};
            end
            ST_D_RD: omem_raddr = idx_reg;
            ST_D_CHK:
            begin
                omem_we    = found_reg;
                omem_waddr = idx_reg - 1'b1;
                omem_wdata = omem_rdata;
            end
            ST_T_HEAD: omem_raddr = '0;
            ST_T_HD:   dmem_raddr = omem_rdata;
            ST_T_SRD:  omem_raddr = idx_inc[IW-1:0];
            ST_T_SWR:
            begin
                omem_we    = 1'b1;
                omem_waddr = idx_reg;
                omem_wdata = omem_rdata;
            end
            default:
            begin
                omem_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        item_next       = item_reg;
        busy_next       = busy_reg;
        live_next       = live_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        slot_next       = slot_reg;
        found_next      = found_reg;
        nd_next         = nd_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        hdl_next        = hdl_reg;
        htag_next       = htag_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                end
            end
            ST_DISPATCH:
            begin
                idx_next        = '0;
                pos_next        = live_reg;
                found_next      = 1'b0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                slot_next       = free_slot;
                nd_next         = (item_reg.deadline - item_reg.now) ^ SIGN_BIT;
                if (item_reg.mode == MODE_ADD)
                    res_next = '{kind: KIND_FULL, slot: 4'd0, tag_out: 32'd0, last: 1'b1};
                else
                    res_next = '{kind: KIND_BAD_ID, slot: item_reg.target_slot,
                                 tag_out: 32'd0, last: 1'b1};
            end
            ST_A_CMP:
            begin
                if (closer || idx_inc == live_ext)
                begin
                    pos_next = closer ? idx_reg : live_reg;
                    idx_next = live_reg;
                end
                else
                begin
                    idx_next = idx_inc[IW-1:0];
                end
            end
            ST_A_SWR: idx_next = idx_reg - 1'b1;
            ST_A_PUT:
            begin
                busy_next[slot_reg] = 1'b1;
                live_next = live_reg + 1'b1;
                res_next  = '{kind: KIND_ADDED, slot: to_slot4(slot_reg),
                              tag_out: 32'd0, last: 1'b1};
            end
            ST_D_CHK:
            begin
                if ({4'b0, omem_rdata} == tgt_ext)
                    found_next = 1'b1;
                idx_next = idx_inc[IW-1:0];
            end
            ST_D_DONE:
            begin
                if (found_reg)
                    live_next = live_reg - 1'b1;
                busy_next[tgt_idx] = 1'b0;
                res_next = '{kind: KIND_DELETED, slot: item_reg.target_slot,
                             tag_out: 32'd0, last: 1'b1};
            end
            ST_T_HD: slot_next = omem_rdata;
            ST_T_DL:
            begin
                hdl_next  = dmem_rdata[63:32];
                htag_next = dmem_rdata[31:0];
            end
            ST_T_EVAL:
            begin
                if (expired && !(pend_valid_reg && !can_load))
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{kind: KIND_EXPIRED, slot: to_slot4(pend_slot_reg),
                                           tag_out: pend_tag_reg, last: 1'b0};
                    end
                    pend_valid_next     = 1'b1;
                    pend_slot_next      = slot_reg;
                    pend_tag_next       = htag_reg;
                    busy_next[slot_reg] = 1'b0;
                    cnt_next            = cnt_reg + 1'b1;
                    idx_next            = '0;
                    if (live_reg == IW'(1))
                        live_next = '0;
                end
            end
            ST_T_SWR:
            begin
                idx_next = idx_inc[IW-1:0];
                if (idx_inc2 == live_ext)
                    live_next = live_reg - 1'b1;
            end
            ST_T_FIN:
            begin
                if (pend_valid_reg && can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '{kind: KIND_EXPIRED, slot: to_slot4(pend_slot_reg),
                                        tag_out: pend_tag_reg, last: 1'b1};
                    pend_valid_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            live_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            live_reg       <= live_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        slot_reg      <= slot_next;
        found_reg     <= found_next;
        nd_reg        <= nd_next;
        cnt_reg       <= cnt_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        hdl_reg       <= hdl_next;
        htag_reg      <= htag_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// ===== hdl/sorted_timeout_queue_top.sv =====
// top level of the sorted timeout queue
`timescale 1ns / 1ps

// Deadline-ordered queue of up to SLOTS-1 one-shot timeouts, ordered by the signed
// distance deadline - now. One item is worked at a time; in_stall is high from the
// transfer until its last result, if any, has been loaded into the output register,
// and a stalled output register holds the work up. The order ram and the timer ram
// each have a registered read port. An add scans the queue for the first entry with
// a later deadline and shifts the entries behind it back by one; a valid delete
// scans every pending timer and closes the gap; a tick pops the head while it has
// expired, shifting the rest forward, until the queue empties or 15 timers are popped.
module sorted_timeout_queue_top #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  stq_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output stq_pkg::out_t out_data
);

    import stq_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic          omem_we;
    logic [IW-1:0] omem_waddr;
    logic [IW-1:0] omem_wdata;
    logic [IW-1:0] omem_raddr;
    logic [IW-1:0] omem_rdata;
    logic          dmem_we;
    logic [IW-1:0] dmem_waddr;
    logic [63:0]   dmem_wdata;
    logic [IW-1:0] dmem_raddr;
    logic [63:0]   dmem_rdata;

    stq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .omem_we    (omem_we),
        .omem_waddr (omem_waddr),
        .omem_wdata (omem_wdata),
        .omem_raddr (omem_raddr),
        .omem_rdata (omem_rdata),
        .dmem_we    (dmem_we),
        .dmem_waddr (dmem_waddr),
        .dmem_wdata (dmem_wdata),
        .dmem_raddr (dmem_raddr),
        .dmem_rdata (dmem_rdata)
    );

    // queue order: position to slot id
    stq_ram #(.W(IW), .D(SLOTS)) u_order_ram (
        .clk   (clk),
        .we    (omem_we),
        .waddr (omem_waddr),
        .wdata (omem_wdata),
        .raddr (omem_raddr),
        .rdata (omem_rdata)
    );

    // per slot deadline and tag
    stq_ram #(.W(64), .D(SLOTS)) u_timer_ram (
        .clk   (clk),
        .we    (dmem_we),
        .waddr (dmem_waddr),
        .wdata (dmem_wdata),
        .raddr (dmem_raddr),
        .rdata (dmem_rdata)
    );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the sorted timeout queue
`timescale 1ns / 1ps

module testbench;
    import stq_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;

    sorted_timeout_queue_top #(.SLOTS(NSLOT)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // predictor state
    logic        busy_q [NSLOT];
    logic [31:0] dl_q [NSLOT];
    logic [31:0] tag_q [NSLOT];
    logic [3:0]  order_q [NSLOT];
    int          pending_cnt;

    out_t expected_q[$];
    int   error_count;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   quiet_cycles;
    logic [31:0] clock_now;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] biased(logic [31:0] dl, logic [31:0] now);
        return (dl - now) ^ SIGN_BIT;
    endfunction

    function automatic out_t mk(logic [2:0] k, logic [3:0] s, logic [31:0] t, logic l);
        out_t r;
        r.kind = k;
        r.slot = s;
        r.tag_out = t;
        r.last = l;
        return r;
    endfunction

    task automatic predict_queue(in_t it);
        int s;
        int pos;
        int n;
        logic [31:0] nd;
        logic [3:0] h;
        case (it.mode)
            MODE_ADD:
            begin
                s = 1;
                while (s < NSLOT && busy_q[s])
                    s++;
                if (pending_cnt >= NSLOT - 1 || s >= NSLOT)
                    expected_q.push_back(mk(KIND_FULL, 4'd0, 32'd0, 1'b1));
                else
                begin
                    nd = biased(it.deadline, it.now);
                    pos = pending_cnt;
                    for (int i = 0; i < pending_cnt; i++)
                        if (nd < biased(dl_q[order_q[i]], it.now))
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = pending_cnt; i > pos; i--)
                        order_q[i] = order_q[i - 1];
                    order_q[pos] = s[3:0];
                    busy_q[s] = 1'b1;
                    dl_q[s] = it.deadline;
                    tag_q[s] = it.user_tag;
                    pending_cnt++;
                    expected_q.push_back(mk(KIND_ADDED, s[3:0], 32'd0, 1'b1));
                end
            end
            MODE_DEL:
            begin
                if (it.target_slot == 4'd0 || !busy_q[it.target_slot])
                    expected_q.push_back(mk(KIND_BAD_ID, it.target_slot, 32'd0, 1'b1));
                else
                begin
                    pos = 0;
                    while (pos < pending_cnt && order_q[pos] != it.target_slot)
                        pos++;
                    if (pos < pending_cnt)
                    begin
                        for (int i = pos; i + 1 < pending_cnt; i++)
                            order_q[i] = order_q[i + 1];
                        pending_cnt--;
                    end
                    busy_q[it.target_slot] = 1'b0;
                    expected_q.push_back(mk(KIND_DELETED, it.target_slot, 32'd0, 1'b1));
                end
            end
            MODE_TICK:
            begin
                n = 0;
                while (pending_cnt > 0 && n < MAX_RESULTS)
                begin
                    h = order_q[0];
                    if (((it.now - dl_q[h]) & SIGN_BIT) != 0)
                        break;
                    for (int i = 0; i + 1 < pending_cnt; i++)
                        order_q[i] = order_q[i + 1];
                    pending_cnt--;
                    busy_q[h] = 1'b0;
                    expected_q.push_back(mk(KIND_EXPIRED, h, tag_q[h], 1'b0));
                    n++;
                end
                if (n > 0)
                    expected_q[$].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(logic [1:0] m, logic [31:0] now, logic [31:0] dl,
                             logic [31:0] tg, logic [3:0] ts);
        in_t it;
        it.mode = m;
        it.now = now;
        it.deadline = dl;
        it.user_tag = tg;
        it.target_slot = ts;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_queue(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected transfer kind %0d slot %0d",
                           out_data.kind, out_data.slot);
                    error_count++;
                end
                else
                begin
                    out_t e;
                    e = expected_q.pop_front();
                    if (out_data.kind !== e.kind)
                    begin
                        $error("kind: expected %0d actual %0d", e.kind, out_data.kind);
                        error_count++;
                    end
                    if (out_data.slot !== e.slot)
                    begin
                        $error("slot: expected %0d actual %0d", e.slot, out_data.slot);
                        error_count++;
                    end
                    if (out_data.tag_out !== e.tag_out)
                    begin
                        $error("tag_out: expected %h actual %h", e.tag_out, out_data.tag_out);
                        error_count++;
                    end
                    if (out_data.last !== e.last)
                    begin
                        $error("last: expected %0d actual %0d", e.last, out_data.last);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_item(MODE_TICK, 32'd0, 32'd0, 32'd0, 4'd0);
        send_item(MODE_DEL, 32'd0, 32'd0, 32'd0, 4'd0);
        send_item(MODE_DEL, 32'd0, 32'd0, 32'd0, 4'd15);
        send_item(MODE_DEL, 32'd0, 32'd0, 32'd0, 4'd3);
        send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(MODE_ADD, 32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFFF, 4'd0);
        send_item(MODE_ADD, 32'hFFFF_FFF0, 32'h0000_0010, 32'h1234_5678, 4'd0);
        send_item(MODE_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0, 4'd0);
        send_item(MODE_ADD, 32'hFFFF_FFF0, 32'h7FFF_FFEF, 32'hA5A5_A5A5, 4'd0);
        send_item(MODE_DEL, 32'd0, 32'd0, 32'd0, 4'd2);
        send_item(MODE_DEL, 32'd0, 32'd0, 32'd0, 4'd2);
        send_item(MODE_TICK, 32'hFFFF_FFF7, 32'd0, 32'd0, 4'd0);
        send_item(MODE_TICK, 32'h0000_0010, 32'd0, 32'd0, 4'd0);
        for (int i = 0; i < 16; i++)
            send_item(MODE_ADD, 32'd100, 32'd100 + (i & 3), 32'h100 + i, 4'd0);
        send_item(MODE_TICK, 32'd200, 32'd0, 32'd0, 4'd0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [1:0] m;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            m = (r < 45) ? MODE_ADD : (r < 65) ? MODE_DEL : (r < 97) ? MODE_TICK : 2'd3;
            if (m == MODE_TICK)
                clock_now = clock_now + $urandom_range(40);
            if ($urandom_range(19) == 0)
                send_item(m, $urandom, $urandom, $urandom, 4'($urandom));
            else
                send_item(m, clock_now, clock_now + $urandom_range(60) - 10,
                          $urandom, 4'($urandom_range(15)));
        end
    endtask

    task automatic test_pause();
        wait_drained();
        test_random(20);
    endtask

    initial
    begin
        error_count = 0;
        quiet_cycles = 0;
        pending_cnt = 0;
        clock_now = 32'hFFFF_FF00;
        for (int i = 0; i < NSLOT; i++)
            busy_q[i] = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        sender_idle_pct = 22;
        receiver_idle_pct = 47;
        test_random(100);
        test_pause();
        sender_idle_pct = 47;
        receiver_idle_pct = 22;
        test_random(90);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random(90);
        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
